// ----- rtl/chained_hash_map_engine_core_defines.svh -----
// Assertion macros used by the checker file of the hash map engine.
`ifndef CHAINED_HASH_MAP_ENGINE_CORE_DEFINES_SVH
`define CHAINED_HASH_MAP_ENGINE_CORE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define CHME_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define CHME_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/chme_pkg.sv -----
package chme_pkg;

    localparam int MAX_BUCKETS_DEF = 256;
    localparam int POOL_NODES_DEF  = 1024;

    localparam int BC_W   = 9;
    localparam int MODE_W = 2;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 11;

    localparam logic [BC_W-1:0] BC_RESET = 9'd16;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_DUP    = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    localparam int DIV_STEPS = 8;
    localparam int DIV_BITS  = 8;
    localparam int DVD_W     = DIV_STEPS * DIV_BITS;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;
        logic div_step;
        logic head_rd;
        logic head_ld;
        logic node_rd;
        logic walk_adv;
        logic hit;
        logic pop_rd;
        logic fin;
        logic out_ld;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic cur_nil;
        logic key_match;
        logic need_pop;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/chme_in_if.sv -----
interface chme_in_if;
    import chme_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [KEY_W-1:0]  key;
    logic [VAL_W-1:0]         value;

    modport source (output valid, output mode, output key, output value, input ready);
    modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

// ----- rtl/chme_out_if.sv -----
interface chme_out_if;
    import chme_pkg::*;

    logic              valid;
    logic              ready;
    logic              success;
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  found_value;
    logic [CNT_W-1:0]  entry_count;

    modport source (output valid, output success, output status, output found_value,
                    output entry_count, input ready);
    modport sink   (input valid, input success, input status, input found_value,
                    input entry_count, output ready);
endinterface

// ----- rtl/chme_ctrl.sv -----
module chme_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  chme_pkg::t_sts i_sts,
    output chme_pkg::t_cmd o_cmd
);
    import chme_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DIV  = 9'b000000010,
        S_HRD  = 9'b000000100,
        S_HLD  = 9'b000001000,
        S_WRD  = 9'b000010000,
        S_CMP  = 9'b000100000,
        S_UPD  = 9'b001000000,
        S_POP  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                o_cmd.head_rd = 1'b1;
                n_state       = S_HLD;
            end
            S_HLD: begin
                o_cmd.head_ld = 1'b1;
                n_state       = S_WRD;
            end
            S_WRD: begin
                if (i_sts.cur_nil) begin
                    n_state = S_UPD;
                end else begin
                    o_cmd.node_rd = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.key_match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_UPD;
                end else begin
                    o_cmd.walk_adv = 1'b1;
                    n_state        = S_WRD;
                end
            end
            S_UPD: begin
                if (i_sts.need_pop) begin
                    o_cmd.pop_rd = 1'b1;
                    n_state      = S_POP;
                end else begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_OUT;
                end
            end
            S_POP: begin
                o_cmd.fin = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ----- rtl/chme_datapath.sv -----
module chme_datapath #(
    parameter int MAX_BUCKETS = chme_pkg::MAX_BUCKETS_DEF,
    parameter int POOL_NODES  = chme_pkg::POOL_NODES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [chme_pkg::BC_W-1:0]        i_cfg_wdata,
    input  logic [chme_pkg::MODE_W-1:0]      i_mode,
    input  logic signed [chme_pkg::KEY_W-1:0] i_key,
    input  logic [chme_pkg::VAL_W-1:0]       i_value,
    input  chme_pkg::t_cmd                   i_cmd,
    output chme_pkg::t_sts                   o_sts,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_success,
    output logic [chme_pkg::STAT_W-1:0]      o_status,
    output logic [chme_pkg::VAL_W-1:0]       o_found_value,
    output logic [chme_pkg::CNT_W-1:0]       o_entry_count
);
    import chme_pkg::*;

    localparam int NW = $clog2(POOL_NODES);
    localparam int LW = $clog2(POOL_NODES + 1);
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int RW = ((BW > BC_W) ? BW : BC_W) + 1;
    localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

    logic [BC_W-1:0]         r_bc;
    logic [MODE_W-1:0]       r_mode;
    logic signed [KEY_W-1:0] r_key;
    logic [VAL_W-1:0]        r_value;
    logic [DVD_W-1:0]        r_dvd, n_dvd;
    logic [RW-1:0]           r_rem, n_rem;
    logic [DCNT_W-1:0]       r_dcnt;
    logic [RW-1:0]           v_act;
    logic [BW-1:0]           r_b;
    logic [LW-1:0]           r_head, r_cur, r_prev, r_link;
    logic                    r_found;
    logic [VAL_W-1:0]        r_fval;

    logic [LW-1:0]           m_heads [MAX_BUCKETS];
    logic [LW-1:0]           r_hq;
    logic [MAX_BUCKETS-1:0]  r_hvalid;
    logic                    r_hv_q;

    logic signed [KEY_W-1:0] m_keys  [POOL_NODES];
    logic [VAL_W-1:0]        m_vals  [POOL_NODES];
    logic [LW-1:0]           m_links [POOL_NODES];
    logic [NW-1:0]           m_free  [POOL_NODES];
    logic signed [KEY_W-1:0] r_kq;
    logic [VAL_W-1:0]        r_vq;
    logic [LW-1:0]           r_lq;
    logic [NW-1:0]           r_fq;
    logic                    r_pop_fresh;
    logic [NW-1:0]           r_pop_idx;
    logic [NW-1:0]           v_pidx;

    logic [LW-1:0]           r_ftop, n_ftop, r_low;
    logic [NW-1:0]           v_new;
    logic                    v_ins, v_del;
    logic                    n_ok;
    logic [STAT_W-1:0]       n_stat;
    logic [VAL_W-1:0]        n_fval;

    logic                    r_rsucc;
    logic [STAT_W-1:0]       r_rstat;
    logic [VAL_W-1:0]        r_rfval;
    logic [CNT_W-1:0]        r_rcnt;

    always_comb begin
        if (r_bc == '0) begin
            v_act = RW'(1);
        end else if (32'(r_bc) > MAX_BUCKETS) begin
            v_act = RW'(MAX_BUCKETS);
        end else begin
            v_act = RW'(r_bc);
        end
    end

    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        for (int i = 0; i < DIV_BITS; i++) begin
            n_rem = {n_rem[RW-2:0], n_dvd[DVD_W-1]};
            n_dvd = {n_dvd[DVD_W-2:0], 1'b0};
            if (n_rem >= v_act) begin
                n_rem = n_rem - v_act;
            end
        end
    end

    assign v_pidx = NW'(r_ftop - LW'(1));
    assign v_new  = r_pop_fresh ? (NW'(POOL_NODES - 1) - r_pop_idx) : r_fq;
    assign v_ins  = i_cmd.fin && (r_mode == MODE_INSERT) && !r_found && (r_ftop != '0);
    assign v_del  = i_cmd.fin && (r_mode == MODE_DELETE) && r_found;

    always_comb begin
        n_ok   = 1'b0;
        n_stat = ST_ABSENT;
        n_fval = '0;
        n_ftop = r_ftop;
        priority if (r_mode == MODE_INSERT) begin
            if (r_found) begin
                n_stat = ST_DUP;
            end else if (r_ftop == '0) begin
                n_stat = ST_FULL;
            end else begin
                n_ok   = 1'b1;
                n_stat = ST_OK;
                n_ftop = r_ftop - LW'(1);
            end
        end else if (r_mode == MODE_DELETE) begin
            if (r_found) begin
                n_ok   = 1'b1;
                n_stat = ST_OK;
                n_ftop = (r_ftop < NIL) ? (r_ftop + LW'(1)) : r_ftop;
            end
        end else begin
            if (r_found) begin
                n_ok   = 1'b1;
                n_stat = ST_OK;
                n_fval = r_fval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_bc     <= i_rst_n ? i_cfg_wdata : BC_RESET;
            r_hvalid <= '0;
            r_ftop   <= NIL;
            r_low    <= NIL;
        end else begin
            if (v_ins) begin
                r_hvalid[r_b] <= 1'b1;
            end
            if (i_cmd.fin) begin
                r_ftop <= n_ftop;
                r_low  <= (n_ftop < r_low) ? n_ftop : r_low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_key   <= i_key;
            r_value <= i_value;
            r_dvd   <= {{(DVD_W - KEY_W){i_key[KEY_W-1]}}, i_key};
            r_rem   <= '0;
            r_dcnt  <= '0;
            r_found <= 1'b0;
            r_fval  <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd  <= n_dvd;
            r_rem  <= n_rem;
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
        if (i_cmd.head_rd) begin
            r_hq   <= m_heads[r_rem[BW-1:0]];
            r_hv_q <= r_hvalid[r_rem[BW-1:0]];
            r_b    <= r_rem[BW-1:0];
        end
        if (i_cmd.head_ld) begin
            r_cur  <= r_hv_q ? r_hq : NIL;
            r_head <= r_hv_q ? r_hq : NIL;
            r_prev <= NIL;
        end
        if (i_cmd.node_rd) begin
            r_kq <= m_keys[r_cur[NW-1:0]];
            r_vq <= m_vals[r_cur[NW-1:0]];
            r_lq <= m_links[r_cur[NW-1:0]];
        end
        if (i_cmd.walk_adv) begin
            r_prev <= r_cur;
            r_cur  <= r_lq;
        end
        if (i_cmd.hit) begin
            r_found <= 1'b1;
            r_link  <= r_lq;
            r_fval  <= r_vq;
        end
        if (i_cmd.pop_rd) begin
            r_fq        <= m_free[v_pidx];
            r_pop_idx   <= v_pidx;
            r_pop_fresh <= LW'(v_pidx) < r_low;
        end
        if (i_cmd.fin) begin
            r_rsucc <= n_ok;
            r_rstat <= n_stat;
            r_rfval <= n_fval;
            r_rcnt  <= CNT_W'(NIL - n_ftop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_ins) begin
            m_keys[v_new] <= r_key;
            m_vals[v_new] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (v_ins) begin
            m_links[v_new] <= r_head;
        end else if (v_del && (r_prev < NIL)) begin
            m_links[r_prev[NW-1:0]] <= r_link;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (v_ins) begin
            m_heads[r_b] <= LW'(v_new);
        end else if (v_del && (r_prev >= NIL)) begin
            m_heads[r_b] <= r_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_del && (r_ftop < NIL)) begin
            m_free[r_ftop[NW-1:0]] <= r_cur[NW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            o_success     <= r_rsucc;
            o_status      <= r_rstat;
            o_found_value <= r_rfval;
            o_entry_count <= r_rcnt;
        end
    end

    assign o_sts.div_last  = (r_dcnt == DCNT_W'(DIV_STEPS - 1));
    assign o_sts.cur_nil   = (r_cur >= NIL);
    assign o_sts.key_match = (r_kq == r_key);
    assign o_sts.need_pop  = (r_mode == MODE_INSERT) && !r_found && (r_ftop != '0);
    assign o_sts.out_free  = !o_out_valid || i_out_ready;
endmodule

// ----- rtl/chained_hash_map_engine_core.sv -----
// Flow: after acceptance the key is reduced modulo the bucket count, the bucket head is read and
// loaded, the chain is walked node by node, an insert that takes a node pops it from the pool,
// and the result is registered. One transaction is handled at a time; the bucket modulo (8
// dividend bits a cycle) and the node read per chain step set how long each one takes.
// Reset is synchronous and active low; it empties every bucket, frees every node and
// sets the bucket count to 16, all within the reset cycle.
module chained_hash_map_engine_core #(
    parameter int MAX_BUCKETS = chme_pkg::MAX_BUCKETS_DEF,
    parameter int POOL_NODES  = chme_pkg::POOL_NODES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [chme_pkg::BC_W-1:0] i_cfg_wdata,
    chme_in_if.sink                   i_in,
    chme_out_if.source                o_out
);
    import chme_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    chme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    chme_datapath #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .POOL_NODES  (POOL_NODES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_mode        (i_in.mode),
        .i_key         (i_in.key),
        .i_value       (i_in.value),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_success     (o_out.success),
        .o_status      (o_out.status),
        .o_found_value (o_out.found_value),
        .o_entry_count (o_out.entry_count)
    );
endmodule

// ----- rtl/chme_checker.sv -----
`include "chained_hash_map_engine_core_defines.svh"

module chme_checker #(
    parameter int POOL_NODES = chme_pkg::POOL_NODES_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_success,
    input logic [chme_pkg::STAT_W-1:0] i_out_status,
    input logic [chme_pkg::VAL_W-1:0]  i_out_found_value,
    input logic [chme_pkg::CNT_W-1:0]  i_out_entry_count
);
    import chme_pkg::*;

    `CHME_ASSERT(a_succ_status, i_out_valid |-> (i_out_success == (i_out_status == ST_OK)), "Success disagrees with status.")
    `CHME_ASSERT(a_fail_zero, (i_out_valid && !i_out_success) |-> (i_out_found_value == '0), "Failed transaction carries a value.")
    `CHME_ASSERT(a_count_range, i_out_valid |-> (32'(i_out_entry_count) <= POOL_NODES), "Entry count exceeds the pool.")
    `CHME_ASSERT(a_busy_after_accept, (i_in_valid && i_in_ready) |=> !i_in_ready, "Input taken while a transaction is in progress.")
    `CHME_ASSERT_ALWAYS(a_rst_clears, !i_rst_n |=> !i_out_valid, "Result valid after reset.")
endmodule

bind chained_hash_map_engine_core chme_checker #(
    .POOL_NODES (POOL_NODES)
) u_chme_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_success     (o_out.success),
    .i_out_status      (o_out.status),
    .i_out_found_value (o_out.found_value),
    .i_out_entry_count (o_out.entry_count)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import chme_pkg::*;

    localparam int NBKT = MAX_BUCKETS_DEF;
    localparam int NPOOL = POOL_NODES_DEF;
    localparam int NUM_RANDOM = 500;

    typedef struct packed {
        logic              success;
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  found_value;
        logic [CNT_W-1:0]  entry_count;
    } t_result;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        bit                typed;
        t_result           res;
    } t_row;

    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [BC_W-1:0] i_cfg_wdata = '0;

    chme_in_if  in_ch ();
    chme_out_if out_ch ();

    chained_hash_map_engine_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.mode = '0;
        in_ch.key = '0;
        in_ch.value = '0;
        out_ch.ready = 1'b0;
    end

    // Shadow of the map: a key-to-value table, cleared whenever the bucket count is written.
    logic [BC_W-1:0]   shadow_buckets;
    logic [VAL_W-1:0]  shadow_map[logic [KEY_W-1:0]];
    t_result           pending_results[$];
    int                errors = 0;
    logic [KEY_W-1:0]  used_keys[$];
    bit                sink_hold = 1'b0;
    bit                random_sink = 1'b1;
    int                sink_wait = 0;

    // Membership does not depend on the bucket count; only the pool limit matters.
    function automatic t_result map_apply(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                          logic [VAL_W-1:0] value);
        t_result r;
        bit      present;
        present = shadow_map.exists(key);
        r = '{success: 1'b0, status: ST_ABSENT, found_value: '0, entry_count: '0};
        if (mode == MODE_INSERT) begin
            if (present) begin
                r.status = ST_DUP;
            end else if (shadow_map.num() >= NPOOL) begin
                r.status = ST_FULL;
            end else begin
                shadow_map[key] = value;
                r.success = 1'b1;
                r.status = ST_OK;
            end
        end else if (mode == MODE_DELETE) begin
            if (present) begin
                shadow_map.delete(key);
                r.success = 1'b1;
                r.status = ST_OK;
            end
        end else if (present) begin
            r.success = 1'b1;
            r.status = ST_OK;
            r.found_value = shadow_map[key];
        end
        r.entry_count = CNT_W'(shadow_map.num());
        return r;
    endfunction

    task automatic send_op(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                           logic [VAL_W-1:0] value, int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.key <= key;
        in_ch.value <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(map_apply(mode, key, value));
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_buckets(logic [BC_W-1:0] count);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_buckets = count;
        shadow_map.delete();
        used_keys.delete();
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        case ($urandom_range(0, 3))
            0: pick_key = $urandom_range(0, 40);
            1: pick_key = 32'h8000_0000 | $urandom_range(0, 40);
            default: pick_key = $urandom;
        endcase
        used_keys.push_back(pick_key);
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.success, out_ch.status, out_ch.found_value, out_ch.entry_count};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display("%0t: expected %p, actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (sink_hold || !i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (!random_sink) begin
            out_ch.ready <= 1'b1;
        end else if (out_ch.ready && out_ch.valid) begin
            sink_wait = $urandom_range(0, 15);
            out_ch.ready <= (sink_wait == 0);
        end else if (sink_wait > 0) begin
            sink_wait--;
            out_ch.ready <= (sink_wait == 0);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    initial begin
        #100ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_result res;
        int      gap;
        logic [BC_W-1:0] settings[6];

        settings = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd7, 9'd16};
        shadow_buckets = BC_RESET;
        rows = '{
            '{MODE_SEARCH, 32'h0000_0000, 32'h0, 1'b1, '{1'b0, ST_ABSENT, 32'h0, 11'd0}},
            '{MODE_DELETE, 32'h7FFF_FFFF, 32'h0, 1'b1, '{1'b0, ST_ABSENT, 32'h0, 11'd0}},
            '{MODE_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              '{1'b1, ST_OK, 32'h0, 11'd1}},
            '{MODE_INSERT, 32'h8000_0000, 32'h0, 1'b1, '{1'b1, ST_OK, 32'h0, 11'd2}},
            '{MODE_INSERT, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, '{default: '0}},
            '{MODE_INSERT, 32'h0000_0000, 32'hA5A5_5A5A, 1'b0, '{default: '0}},
            '{MODE_INSERT, 32'h0000_0010, 32'h5A5A_A5A5, 1'b0, '{default: '0}},
            '{MODE_INSERT, 32'h8000_0000, 32'h1, 1'b1, '{1'b0, ST_DUP, 32'h0, 11'd5}},
            '{MODE_SEARCH, 32'h7FFF_FFFF, 32'h0, 1'b1,
              '{1'b1, ST_OK, 32'hFFFF_FFFF, 11'd5}},
            '{MODE_SPARE, 32'h0000_0000, 32'h0, 1'b0, '{default: '0}},
            '{MODE_SEARCH, 32'h0000_0010, 32'h0, 1'b0, '{default: '0}},
            '{MODE_DELETE, 32'h0000_0010, 32'h0, 1'b0, '{default: '0}},
            '{MODE_DELETE, 32'h0000_0000, 32'h0, 1'b0, '{default: '0}},
            '{MODE_SEARCH, 32'h0000_0000, 32'h0, 1'b0, '{default: '0}},
            '{MODE_DELETE, 32'hFFFF_FFFF, 32'h0, 1'b0, '{default: '0}},
            '{MODE_SPARE, 32'h8000_0000, 32'h0, 1'b0, '{default: '0}}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_op(rows[i].mode, rows[i].key, rows[i].value, $urandom_range(0, 15));
            if (rows[i].typed && pending_results[$] !== rows[i].res) begin
                $display("%0t: row %0d expected %p, actual %p", $time, i,
                         rows[i].res, pending_results[$]);
                errors++;
            end
        end

        // The pool is filled in a single bucket, then a duplicate, one more insert, a delete and a retried insert.
        write_buckets(9'd1);
        random_sink = 1'b0;
        for (int i = 0; i < NPOOL; i++) begin
            send_op(MODE_INSERT, KEY_W'(i * 3), $urandom, 0);
            if (i % 64 == 0) drain_results();
        end
        send_op(MODE_INSERT, 32'h0, 32'h1, 0);
        send_op(MODE_INSERT, 32'h7FFF_FFFF, 32'h1, 0);
        send_op(MODE_DELETE, 32'h0, 32'h0, 0);
        send_op(MODE_INSERT, 32'h7FFF_FFFF, 32'h2, 0);
        random_sink = 1'b1;

        foreach (settings[s]) begin
            write_buckets(settings[s]);
            for (int i = 0; i < NUM_RANDOM / 6; i++) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                if (s == 2 && i == 20) begin
                    fork
                        begin
                            sink_hold = 1'b1;
                            repeat (300) @(posedge i_clk);
                            sink_hold = 1'b0;
                        end
                    join_none
                end
                if (i == 40) drain_results();
                send_op((i < 15) ? MODE_INSERT : MODE_W'($urandom_range(0, 3)), pick_key(),
                        $urandom, (s == 4) ? 0 : gap);
            end
        end

        drain_results();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ----- chained_hash_map_engine_core.f -----
+incdir+rtl
rtl/chme_pkg.sv
rtl/chme_in_if.sv
rtl/chme_out_if.sv
rtl/chme_ctrl.sv
rtl/chme_datapath.sv
rtl/chained_hash_map_engine_core.sv
rtl/chme_checker.sv
sim/testbench.sv
